// ----- rtl/core/sgowi_pkg.sv -----
// ----------------------------------------------------------------------------
// sgowi_pkg
// Shared widths, types and register codes of the output write indexer.
// ----------------------------------------------------------------------------
package sgowi_pkg;

	localparam int LANE_W        = 6;
	localparam int VALUE_W       = 32;
	localparam int ADDR_W        = 24;
	localparam int ROWS_W        = 13;
	localparam int COLS_W        = 13;
	localparam int TCOLS_W       = 7;
	localparam int CTILES_W      = 13;
	localparam int ROW_CNT_W     = 12;
	localparam int TILE_CNT_W    = 12;
	localparam int RES_CNT_W     = 25;
	localparam int GRP_CNT_W     = 13;
	localparam int PADDED_W      = CTILES_W + TCOLS_W;
	localparam int TARGET_W      = ROWS_W + PADDED_W;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int QUEUE_DEPTH   = 4;
	localparam int DEF_MAX_LANES = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUT_ROWS  = 2'd0,
		CFG_OUT_COLS  = 2'd1,
		CFG_TILE_COLS = 2'd2,
		CFG_COL_TILES = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [LANE_W-1:0]  lane;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic               write_enable;
		logic [ADDR_W-1:0]  write_address;
		logic [VALUE_W-1:0] write_data;
		logic               row_group_done;
		logic               all_done;
		logic               bad_lane;
	} result_t;

	typedef struct packed {
		logic [ROWS_W-1:0]   out_rows;
		logic [COLS_W-1:0]   out_cols;
		logic [TCOLS_W-1:0]  tile_cols;
		logic [CTILES_W-1:0] col_tiles;
		logic [PADDED_W-1:0] padded;
		logic [TARGET_W-1:0] target;
	} cfg_t;

	typedef struct packed {
		logic [LANE_W-1:0]  lane;
		logic [VALUE_W-1:0] value;
		logic               bad;
	} qword_t;

endpackage

// ----- rtl/core/sgowi_stream_if.sv -----
// ----------------------------------------------------------------------------
// sgowi_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface sgowi_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/sgowi_front.sv -----
// ----------------------------------------------------------------------------
// sgowi_front
// Accepts words, flags lanes beyond the tile or MAX_LANES, feeds the queue.
// ----------------------------------------------------------------------------
module sgowi_front #(
	parameter int MAX_LANES = sgowi_pkg::DEF_MAX_LANES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sgowi_pkg::cfg_t     cfg_st,
	input  logic                hold,
	sgowi_stream_if.sink        item,
	output logic                push_valid,
	output sgowi_pkg::qword_t   push_word,
	input  logic                push_ready
);
	import sgowi_pkg::*;

	localparam int LIM_W = 9;

	logic             f_valid_q;
	qword_t           f_word_q;
	logic [LIM_W-1:0] lane_ext;
	logic             bad;
	logic             accept;

	assign lane_ext   = LIM_W'(item.payload.lane);
	assign bad        = ({1'b0, item.payload.lane} >= cfg_st.tile_cols)
	                 || (lane_ext >= LIM_W'(MAX_LANES));
	assign item.ready = !hold && (!f_valid_q || push_ready);
	assign accept     = item.valid && item.ready;

	assign push_valid = f_valid_q;
	assign push_word  = f_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_q <= 1'b0;
		end else if (accept) begin
			f_valid_q <= 1'b1;
		end else if (push_ready) begin
			f_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f_word_q.lane  <= item.payload.lane;
			f_word_q.value <= item.payload.value;
			f_word_q.bad   <= bad;
		end
	end

endmodule

// ----- rtl/core/sgowi_queue.sv -----
// ----------------------------------------------------------------------------
// sgowi_queue
// Short FIFO between the classifying front and the indexing back end.
// ----------------------------------------------------------------------------
module sgowi_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  sgowi_pkg::qword_t push_word,
	output logic              push_ready,
	output logic              pop_valid,
	output sgowi_pkg::qword_t pop_word,
	input  logic              pop_ready
);
	import sgowi_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	qword_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_word   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ----- rtl/core/sgowi_back.sv -----
// ----------------------------------------------------------------------------
// sgowi_back
// Per-lane tile counters, address arithmetic, row and completion counting.
// ----------------------------------------------------------------------------
module sgowi_back #(
	parameter int MAX_LANES = sgowi_pkg::DEF_MAX_LANES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sgowi_pkg::cfg_t   cfg_st,
	input  logic              pop_valid,
	input  sgowi_pkg::qword_t pop_word,
	output logic              pop_ready,
	sgowi_stream_if.source    result
);
	import sgowi_pkg::*;

	localparam int IDX_W  = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int ENT_W  = ROW_CNT_W + TILE_CNT_W;
	localparam int PCOL_W = TILE_CNT_W + TCOLS_W;
	localparam int PROW_W = ROW_CNT_W + COLS_W;
	localparam int COL_W  = PADDED_W;

	// lane counter memory, row in the upper half
	logic [ENT_W-1:0]     lane_mem_q [MAX_LANES];
	logic [MAX_LANES-1:0] lane_vld_q;

	// stage 1: counter read and update, products
	logic                 s1_valid;
	logic [LANE_W-1:0]    lane_s1;
	logic [VALUE_W-1:0]   value_s1;
	logic                 bad_s1;
	logic [ENT_W-1:0]     rd_s1;
	logic                 fwd_hit_s1;
	logic [ENT_W-1:0]     fwd_s1;

	// stage 2: address, padding check, global counts
	logic                 s2_valid;
	logic [LANE_W-1:0]    lane_s2;
	logic [VALUE_W-1:0]   value_s2;
	logic                 bad_s2;
	logic [PCOL_W-1:0]    pcol_s2;
	logic [PROW_W-1:0]    prow_s2;

	logic                 res_valid_q;
	result_t              res_q;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic [GRP_CNT_W-1:0] grp_cnt_q;
	logic                 finished_q;

	logic                 s1_load;
	logic                 s1_adv;
	logic                 s2_adv;
	logic [IDX_W-1:0]     head_idx;
	logic [IDX_W-1:0]     idx_s1;
	logic [ENT_W-1:0]     cur;
	logic [ROW_CNT_W-1:0] cur_row;
	logic [TILE_CNT_W-1:0] cur_ct;
	logic [TILE_CNT_W:0]  nxt_ct;
	logic                 wrap;
	logic [ENT_W-1:0]     upd;
	logic [PCOL_W-1:0]    pcol;
	logic [PROW_W-1:0]    prow;
	logic [COL_W-1:0]     col;
	logic                 we;
	logic [ADDR_W-1:0]    addr;
	logic [GRP_CNT_W-1:0] grp_inc;
	logic                 pulse;
	logic [RES_CNT_W-1:0] cnt_inc;
	logic                 fin_new;

	assign s2_adv    = s2_valid && (!res_valid_q || result.ready);
	assign s1_adv    = s1_valid && (!s2_valid || s2_adv);
	assign pop_ready = !s1_valid || s1_adv;
	assign s1_load   = pop_valid && pop_ready;
	assign head_idx  = IDX_W'(pop_word.lane);
	assign idx_s1    = IDX_W'(lane_s1);

	// stage 1 counter update
	always_comb begin
		if (fwd_hit_s1) begin
			cur = fwd_s1;
		end else if (lane_vld_q[idx_s1]) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
		cur_row = cur[ENT_W-1:TILE_CNT_W];
		cur_ct  = cur[TILE_CNT_W-1:0];
		nxt_ct  = {1'b0, cur_ct} + (TILE_CNT_W+1)'(1);
		wrap    = (nxt_ct >= cfg_st.col_tiles) || nxt_ct[TILE_CNT_W];
		if (wrap) begin
			upd = {cur_row + ROW_CNT_W'(1), TILE_CNT_W'(0)};
		end else begin
			upd = {cur_row, nxt_ct[TILE_CNT_W-1:0]};
		end
		pcol = PCOL_W'(cur_ct) * PCOL_W'(cfg_st.tile_cols);
		prow = PROW_W'(cur_row) * PROW_W'(cfg_st.out_cols);
	end

	// stage 2 address and counts
	always_comb begin
		col     = COL_W'(pcol_s2) + COL_W'(lane_s2);
		we      = col < COL_W'(cfg_st.out_cols);
		addr    = prow_s2[ADDR_W-1:0] + ADDR_W'(col);
		grp_inc = grp_cnt_q + GRP_CNT_W'(1);
		pulse   = PADDED_W'(grp_inc) == cfg_st.padded;
		cnt_inc = (res_cnt_q == '1) ? res_cnt_q : res_cnt_q + RES_CNT_W'(1);
		fin_new = finished_q || (TARGET_W'(cnt_inc) == cfg_st.target);
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			rd_s1 <= lane_mem_q[head_idx];
		end
		if (s1_adv && !bad_s1) begin
			lane_mem_q[idx_s1] <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_vld_q  <= '0;
			s1_valid    <= 1'b0;
			fwd_hit_s1  <= 1'b0;
			s2_valid    <= 1'b0;
			res_valid_q <= 1'b0;
			res_cnt_q   <= '0;
			grp_cnt_q   <= '0;
			finished_q  <= 1'b0;
		end else begin
			if (s1_adv && !bad_s1) begin
				lane_vld_q[idx_s1] <= 1'b1;
			end
			if (s1_load) begin
				s1_valid   <= 1'b1;
				fwd_hit_s1 <= s1_adv && !bad_s1 && (lane_s1 == pop_word.lane);
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid <= 1'b1;
			end else if (s2_adv) begin
				s2_valid <= 1'b0;
			end
			if (s2_adv) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (s2_adv && !bad_s2) begin
				res_cnt_q  <= cnt_inc;
				grp_cnt_q  <= pulse ? '0 : grp_inc;
				finished_q <= fin_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			lane_s1  <= pop_word.lane;
			value_s1 <= pop_word.value;
			bad_s1   <= pop_word.bad;
			fwd_s1   <= upd;
		end
		if (s1_adv) begin
			lane_s2  <= lane_s1;
			value_s2 <= value_s1;
			bad_s2   <= bad_s1;
			pcol_s2  <= pcol;
			prow_s2  <= prow;
		end
		if (s2_adv) begin
			if (bad_s2) begin
				res_q.write_enable   <= 1'b0;
				res_q.write_address  <= '0;
				res_q.write_data     <= '0;
				res_q.row_group_done <= 1'b0;
				res_q.all_done       <= finished_q;
				res_q.bad_lane       <= 1'b1;
			end else begin
				res_q.write_enable   <= we;
				res_q.write_address  <= addr;
				res_q.write_data     <= value_s2;
				res_q.row_group_done <= pulse;
				res_q.all_done       <= fin_new;
				res_q.bad_lane       <= 1'b0;
			end
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("completion flag dropped");

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.bad_lane) |-> (!res_q.write_enable && !res_q.row_group_done))
		else $error("ignored lane produced a write or row pulse");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_adv) |=> (s1_valid && $stable(lane_s1) && $stable(cur)))
		else $error("stalled counter stage changed");

	a_bad_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_adv && bad_s2) |=> ($stable(res_cnt_q) && $stable(grp_cnt_q)))
		else $error("ignored lane moved the result counts");

endmodule

// ----- rtl/core/sparse_gemm_output_write_indexer_top.sv -----
// ----------------------------------------------------------------------------
// sparse_gemm_output_write_indexer_top
// Turns lane-tagged result words into row-major output matrix writes.
//
//   channel  dir  word
//   cfg      in   index, wdata   register write, always ready
//   item     in   lane, value    one reduced result
//   result   out  write fields   one per item, in order
//
// one item per cycle when results are taken and no register write settles;
// an item passes the front register, queue, counter stage, address stage and
// output register; the per-lane counter memory is read as the item enters the
// counter stage, with forwarding; reset clears all lane counters at once
// through per-lane valid bits; items are held off during a register write
// and while the padded width and total count are rebuilt
// result stalls fill the queue before the item channel drops ready
// ----------------------------------------------------------------------------
module sparse_gemm_output_write_indexer_top #(
	parameter int MAX_LANES = sgowi_pkg::DEF_MAX_LANES
) (
	input  logic           clk,
	input  logic           arst_n,
	sgowi_stream_if.sink   cfg,
	sgowi_stream_if.sink   item,
	sgowi_stream_if.source result
);
	import sgowi_pkg::*;

	logic [ROWS_W-1:0]   out_rows_q;
	logic [COLS_W-1:0]   out_cols_q;
	logic [TCOLS_W-1:0]  tile_cols_q;
	logic [CTILES_W-1:0] col_tiles_q;
	logic [PADDED_W-1:0] padded_q;
	logic [TARGET_W-1:0] target_q;
	logic [1:0]          settle_q;
	logic                cfg_wr;
	cfg_wr_t             cfg_word;
	cfg_t                cfg_st;
	logic                push_valid;
	qword_t              push_word;
	logic                push_ready;
	logic                pop_valid;
	qword_t              pop_word;
	logic                pop_ready;

	assign cfg.ready = 1'b1;
	assign cfg_word  = cfg.payload;
	assign cfg_wr    = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_rows_q  <= ROWS_W'(1);
			out_cols_q  <= COLS_W'(1);
			tile_cols_q <= TCOLS_W'(1);
			col_tiles_q <= CTILES_W'(1);
			padded_q    <= PADDED_W'(1);
			target_q    <= TARGET_W'(1);
			settle_q    <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_word.index)
					CFG_OUT_ROWS:  out_rows_q  <= cfg_word.wdata;
					CFG_OUT_COLS:  out_cols_q  <= cfg_word.wdata;
					CFG_TILE_COLS: tile_cols_q <= cfg_word.wdata[TCOLS_W-1:0];
					CFG_COL_TILES: col_tiles_q <= cfg_word.wdata;
					default: begin
					end
				endcase
				settle_q <= 2'd2;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
			padded_q <= PADDED_W'(col_tiles_q) * PADDED_W'(tile_cols_q);
			target_q <= TARGET_W'(out_rows_q) * TARGET_W'(padded_q);
		end
	end

	always_comb begin
		cfg_st.out_rows  = out_rows_q;
		cfg_st.out_cols  = out_cols_q;
		cfg_st.tile_cols = tile_cols_q;
		cfg_st.col_tiles = col_tiles_q;
		cfg_st.padded    = padded_q;
		cfg_st.target    = target_q;
	end

	sgowi_front #(
		.MAX_LANES (MAX_LANES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_st     (cfg_st),
		.hold       (cfg_wr || (settle_q != '0)),
		.item       (item),
		.push_valid (push_valid),
		.push_word  (push_word),
		.push_ready (push_ready)
	);

	sgowi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_word  (push_word),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_word   (pop_word),
		.pop_ready  (pop_ready)
	);

	sgowi_back #(
		.MAX_LANES (MAX_LANES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_st    (cfg_st),
		.pop_valid (pop_valid),
		.pop_word  (pop_word),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the output write indexer against its own model of the lane tile
// counters, row group count and done flag. A directed script runs first,
// then fixed and random register settings with lane passes and noise. A
// final lane 0 sweep runs with no idling.
// ----------------------------------------------------------------------------
module tb_top;
	import sgowi_pkg::*;

	localparam int          MAX_LANES      = 64;
	localparam int          TILE_LIMIT     = 1 << TILE_CNT_W;
	localparam int          RANDOM_PHASES  = 8;
	localparam int          PHASE_ITEMS    = 100;
	localparam int          TAIL_ITEMS     = 150;
	localparam int          HOLD_CYCLES    = 400;
	localparam int          DRAIN_CYCLES   = 20;
	localparam longint      LIMIT_CYCLES   = 1_000_000;

	typedef struct packed {
		logic                  cfg_write;
		cfg_reg_t              reg_idx;
		logic [CFG_DATA_W-1:0] wval;
		item_t                 it;
		logic                  typed;
		result_t               want;
	} step_t;

	localparam item_t   NO_ITEM     = '0;
	localparam result_t NO_RESULT   = '0;
	localparam result_t REJECT_OPEN = '{1'b0, 24'd0, 32'd0, 1'b0, 1'b0, 1'b1};

	localparam int SCRIPT_LEN = 28;
	localparam step_t SCRIPT [0:SCRIPT_LEN-1] = '{
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd1, 32'hFFFF_FFFF}, 1'b1, REJECT_OPEN},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd63, 32'h0000_0000}, 1'b1, REJECT_OPEN},
		'{1'b1, CFG_OUT_ROWS, 13'd2, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b1, CFG_OUT_COLS, 13'd5, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b1, CFG_TILE_COLS, 13'd3, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b1, CFG_COL_TILES, 13'd2, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd0, 32'hAAAA_AAAA}, 1'b1,
			'{1'b1, 24'd0, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0}},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd1, 32'h5555_5555}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd2, 32'hFFFF_FFFF}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd3, 32'h0000_0001}, 1'b1, REJECT_OPEN},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd0, 32'h8000_0000}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd1, 32'h7FFF_FFFF}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd2, 32'h0000_FFFF}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd63, 32'hFFFF_0000}, 1'b1, REJECT_OPEN},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd0, 32'h0F0F_0F0F}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd1, 32'hF0F0_F0F0}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd2, 32'h0000_0000}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd0, 32'h3333_3333}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd1, 32'hCCCC_CCCC}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd2, 32'h1234_5678}, 1'b0, NO_RESULT},
		'{1'b1, CFG_OUT_ROWS, 13'd4096, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b1, CFG_OUT_COLS, 13'd4096, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b1, CFG_TILE_COLS, 13'd64, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b1, CFG_COL_TILES, 13'd4096, NO_ITEM, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd63, 32'h0000_0000}, 1'b1,
			'{1'b1, 24'd63, 32'h0000_0000, 1'b0, 1'b1, 1'b0}},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd0, 32'hFFFF_FFFF}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd32, 32'h8765_4321}, 1'b0, NO_RESULT},
		'{1'b0, CFG_OUT_ROWS, 13'd0, '{6'd63, 32'h0F0F_0F0F}, 1'b0, NO_RESULT}
	};

	logic clk;
	logic arst_n;

	sgowi_stream_if #(.T(cfg_wr_t)) cfg_bus ();
	sgowi_stream_if #(.T(item_t))   item_bus ();
	sgowi_stream_if #(.T(result_t)) result_bus ();

	sparse_gemm_output_write_indexer_top #(
		.MAX_LANES(MAX_LANES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.item  (item_bus),
		.result(result_bus)
	);

	// indexer model state
	logic [CFG_DATA_W-1:0] cfg_rows   = 13'd1;
	logic [CFG_DATA_W-1:0] cfg_cols   = 13'd1;
	logic [TCOLS_W-1:0]    cfg_tcols  = 7'd1;
	logic [CFG_DATA_W-1:0] cfg_ctiles = 13'd1;
	logic [ROW_CNT_W-1:0]  lane_rows  [MAX_LANES] = '{default: '0};
	logic [TILE_CNT_W-1:0] lane_tiles [MAX_LANES] = '{default: '0};
	logic [RES_CNT_W-1:0]  seen_total = '0;
	logic [GRP_CNT_W-1:0]  row_tally  = '0;
	logic                  done_flag  = 1'b0;

	result_t expected_words [$];
	int      mismatches = 0;
	bit      calm       = 1'b0;
	bit      quiet      = 1'b0;
	bit      hold_req   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 20);
		$display("Regression FAIL");
		$finish;
	end

	function automatic result_t index_result(item_t it);
		result_t         r;
		longint unsigned row;
		longint unsigned tile;
		longint unsigned col;
		longint unsigned padded;
		int unsigned     ln;
		r = '0;
		ln = 32'(it.lane);
		if (ln >= cfg_tcols || ln >= MAX_LANES) begin
			r.all_done = done_flag;
			r.bad_lane = 1'b1;
			return r;
		end
		row = 64'(lane_rows[ln]);
		tile = 64'(lane_tiles[ln]);
		col = tile * cfg_tcols + ln;
		r.write_enable = (col < cfg_cols);
		r.write_address = ADDR_W'(row * cfg_cols + col);
		r.write_data = it.value;
		if (tile + 1 >= cfg_ctiles || tile + 1 >= TILE_LIMIT) begin
			lane_tiles[ln] = '0;
			lane_rows[ln] = lane_rows[ln] + 1'b1;
		end else begin
			lane_tiles[ln] = lane_tiles[ln] + 1'b1;
		end
		padded = longint'(cfg_ctiles) * cfg_tcols;
		if (~&seen_total)
			seen_total = seen_total + 1'b1;
		if (seen_total == longint'(cfg_rows) * padded)
			done_flag = 1'b1;
		row_tally = row_tally + 1'b1;
		if (row_tally == padded) begin
			row_tally = '0;
			r.row_group_done = 1'b1;
		end
		r.all_done = done_flag;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			got = result_bus.payload;
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing pending", 64'(got), '0);
			end else begin
				want = expected_words.pop_front();
				if (got.write_enable !== want.write_enable)
					report_mismatch("write_enable", 64'(got.write_enable),
						64'(want.write_enable));
				if (got.write_address !== want.write_address)
					report_mismatch("write_address", 64'(got.write_address),
						64'(want.write_address));
				if (got.write_data !== want.write_data)
					report_mismatch("write_data", 64'(got.write_data),
						64'(want.write_data));
				if (got.row_group_done !== want.row_group_done)
					report_mismatch("row_group_done", 64'(got.row_group_done),
						64'(want.row_group_done));
				if (got.all_done !== want.all_done)
					report_mismatch("all_done", 64'(got.all_done), 64'(want.all_done));
				if (got.bad_lane !== want.bad_lane)
					report_mismatch("bad_lane", 64'(got.bad_lane), 64'(want.bad_lane));
			end
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin : result_ready_gen
		int stall_left;
		bit rdy;
		stall_left = 0;
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				rdy = 1'b0;
			end else if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 16);
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			result_bus.ready <= rdy;
		end
	end

	task automatic send_item(item_t it, bit typed, result_t want);
		result_t calc;
		item_bus.valid <= 1'b1;
		item_bus.payload <= it;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		calc = index_result(it);
		expected_words.insert(expected_words.size(), typed ? want : calc);
	endtask

	task automatic offer(int unsigned ln);
		item_t it;
		it.lane = LANE_W'(ln);
		it.value = $urandom;
		send_item(it, 1'b0, NO_RESULT);
		if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic settle();
		item_bus.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, int unsigned val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.payload <= '{index: idx, wdata: CFG_DATA_W'(val)};
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			CFG_OUT_ROWS:  cfg_rows = CFG_DATA_W'(val);
			CFG_OUT_COLS:  cfg_cols = CFG_DATA_W'(val);
			CFG_TILE_COLS: cfg_tcols = TCOLS_W'(val);
			CFG_COL_TILES: cfg_ctiles = CFG_DATA_W'(val);
			default: ;
		endcase
	endtask

	task automatic write_settings(int unsigned rows, int unsigned cols, int unsigned tcols,
			int unsigned ctiles);
		settle();
		write_register(CFG_OUT_ROWS, rows);
		write_register(CFG_OUT_COLS, cols);
		write_register(CFG_TILE_COLS, tcols);
		write_register(CFG_COL_TILES, ctiles);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned r, c, t, k, sent, pick, first;
		bit paused;
		cfg_bus.valid <= 1'b0;
		cfg_bus.payload <= '0;
		item_bus.valid <= 1'b0;
		item_bus.payload <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].cfg_write) begin
				settle();
				write_register(SCRIPT[i].reg_idx, SCRIPT[i].wval);
			end else begin
				if (i > 0 && SCRIPT[i-1].cfg_write)
					cfg_bus.valid <= 1'b0;
				send_item(SCRIPT[i].it, SCRIPT[i].typed, SCRIPT[i].want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					r = 1; c = 1; t = 1; k = 1;
				end
				1: begin
					r = 4096; c = 4096; t = 64; k = 4096;
				end
				2: begin
					t = 64; k = 1;
					c = $urandom_range(1, 64);
					r = $urandom_range(1, 8);
				end
				default: begin
					t = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
					k = $urandom_range(1, 5);
					c = (k - 1) * t + $urandom_range(1, t);
					if ($urandom_range(0, 5) == 0)
						c = $urandom_range(1, 4096);
					r = $urandom_range(1, 6);
				end
			endcase
			write_settings(r, c, t, k);
			calm = ($urandom_range(0, 3) == 0);
			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				if (ph == 3 && sent == 0)
					hold_req = 1'b1;
				if (ph == 4 && sent >= PHASE_ITEMS / 2 && !paused) begin
					settle();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 9);
				if (pick < 8) begin
					// lane pass in order, partial ones start mid-row
					first = (pick < 6) ? 0 : $urandom_range(0, t - 1);
					for (int unsigned l = first; l < t && l < MAX_LANES; l++) begin
						offer(l);
						sent++;
					end
				end else begin
					offer($urandom_range(0, MAX_LANES - 1));
					sent++;
				end
			end
		end

		// lane 0 alone, one row per word, back to back
		quiet = 1'b1;
		write_settings(1, 4096, 1, 1);
		repeat (TAIL_ITEMS)
			offer(0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/sgowi_pkg.sv
rtl/core/sgowi_stream_if.sv
rtl/core/sgowi_front.sv
rtl/core/sgowi_queue.sv
rtl/core/sgowi_back.sv
rtl/core/sparse_gemm_output_write_indexer_top.sv
sim/tb_top.sv
